[design/erd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_pkg: shared types and constants
// Request and result formats, configuration and state records, codes and
// reset values for the retransmission timer and receive dispatch block.
// ----------------------------------------------------------------------------
package erd_pkg;

	localparam int ADDR_W   = 13;
	localparam int LEN_W    = 11;
	localparam int MAC_W    = 48;
	localparam int TYPE_W   = 16;
	localparam int TICK_W   = 16;
	localparam int TMO_W    = 17;
	localparam int JIT_W    = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [1:0] KIND_TICK = 2'd0;
	localparam logic [1:0] KIND_SEND = 2'd1;
	localparam logic [1:0] KIND_RECV = 2'd2;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_TRANSMIT = 3'd1;
	localparam logic [2:0] ACT_IP       = 3'd2;
	localparam logic [2:0] ACT_ARP      = 3'd3;
	localparam logic [2:0] ACT_DROP     = 3'd4;

	localparam logic [1:0] FATAL_NONE    = 2'd0;
	localparam logic [1:0] FATAL_NO_ACK  = 2'd1;
	localparam logic [1:0] FATAL_RX_PTR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MAC    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MAX  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_START   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OPT_START    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RX_END       = 3'd5;

	localparam logic [TYPE_W-1:0] TYPE_IP  = 16'h0800;
	localparam logic [TYPE_W-1:0] TYPE_ARP = 16'h0806;

	localparam int ETH_HDR_BYTES = 14;
	localparam int ETH_CRC_BYTES = 4;
	localparam logic [TMO_W-1:0] TIMEOUT_CAP = 17'd131071;
	localparam logic [TICK_W-1:0] TICK_SAT = 16'hFFFF;

	localparam logic [MAC_W-1:0]  RST_LOCAL_MAC   = '0;
	localparam logic [TICK_W-1:0] RST_TIMEOUT_MIN = 16'd150;
	localparam logic [TICK_W-1:0] RST_TIMEOUT_MAX = 16'd1200;
	localparam logic [ADDR_W-1:0] RST_PRIO_START  = 13'h1000;
	localparam logic [ADDR_W-1:0] RST_OPT_START   = 13'd5618;
	localparam logic [ADDR_W-1:0] RST_RX_END      = 13'h0FFF;

	typedef struct packed {
		logic [1:0]        kind;
		logic [LEN_W-1:0]  payload_length;
		logic              priority_req;
		logic [ADDR_W-1:0] nxt_frame_ptr;
		logic [LEN_W-1:0]  frame_bytes;
		logic [MAC_W-1:0]  src_mac;
		logic [TYPE_W-1:0] ethertype;
		logic [JIT_W-1:0]  jitter;
	} req_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [ADDR_W-1:0] tx_start;
		logic [ADDR_W-1:0] tx_end;
		logic [LEN_W-1:0]  delivered_length;
		logic [ADDR_W-1:0] header_address;
		logic [ADDR_W-1:0] read_pointer;
		logic [1:0]        fatal;
	} res_t;

	typedef struct packed {
		logic [MAC_W-1:0]  local_mac;
		logic [TICK_W-1:0] timeout_min;
		logic [TICK_W-1:0] timeout_max;
		logic [ADDR_W-1:0] priority_buf_start;
		logic [ADDR_W-1:0] optional_buf_start;
		logic [ADDR_W-1:0] rx_buf_end;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0] ack_ticks;
		logic [TMO_W-1:0]  current_timeout;
		logic [ADDR_W-1:0] pending_end;
		logic              pending_valid;
		logic [ADDR_W-1:0] next_header;
	} state_t;

endpackage

[design/eth_retransmit_and_rx_dispatch.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_retransmit_and_rx_dispatch: retransmission timer and receive dispatch
// Backoff retransmit timer for priority frames and ethertype dispatch with
// receive pointer checks for incoming frame headers.
// ----------------------------------------------------------------------------
// Each request (tick, send or received header) yields exactly one result.
// A request is taken into an input register, evaluated in one pass against
// the timer and pointer state, and its result lands in an output register:
// the result becomes valid when it moves from the input register into the
// output register, which waits while a held result is not yet taken, and
// one request is accepted every cycle while results are taken. Configuration
// writes apply on the clock edge where cfg_wen is high; unused indexes are ignored.
module eth_retransmit_and_rx_dispatch (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  erd_pkg::req_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output erd_pkg::res_t                     out_data,
	input  logic                              cfg_wen,
	input  logic [erd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [erd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import erd_pkg::*;

	cfg_t   cfg_q;
	state_t state_q;
	state_t state_next;
	req_t   req_s1;
	logic   valid_s1;
	res_t   res_next;
	res_t   res_s2;
	logic   valid_s2;
	logic   adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv_s1;
	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	erd_step u_step (
		.req     (req_s1),
		.cfg     (cfg_q),
		.st      (state_q),
		.st_next (state_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_mac          <= RST_LOCAL_MAC;
			cfg_q.timeout_min        <= RST_TIMEOUT_MIN;
			cfg_q.timeout_max        <= RST_TIMEOUT_MAX;
			cfg_q.priority_buf_start <= RST_PRIO_START;
			cfg_q.optional_buf_start <= RST_OPT_START;
			cfg_q.rx_buf_end         <= RST_RX_END;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_LOCAL_MAC:   cfg_q.local_mac          <= cfg_wdata;
				REG_TIMEOUT_MIN: cfg_q.timeout_min        <= cfg_wdata[TICK_W-1:0];
				REG_TIMEOUT_MAX: cfg_q.timeout_max        <= cfg_wdata[TICK_W-1:0];
				REG_PRIO_START:  cfg_q.priority_buf_start <= cfg_wdata[ADDR_W-1:0];
				REG_OPT_START:   cfg_q.optional_buf_start <= cfg_wdata[ADDR_W-1:0];
				REG_RX_END:      cfg_q.rx_buf_end         <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ack_ticks       <= '0;
			state_q.current_timeout <= {1'b0, RST_TIMEOUT_MIN};
			state_q.pending_end     <= '0;
			state_q.pending_valid   <= 1'b0;
			state_q.next_header     <= '0;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

endmodule

[design/erd_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erd_step: single-request evaluation
// Combinational next state and result for one tick, send or receive request.
// ----------------------------------------------------------------------------
module erd_step (
	input  erd_pkg::req_t   req,
	input  erd_pkg::cfg_t   cfg,
	input  erd_pkg::state_t st,
	output erd_pkg::state_t st_next,
	output erd_pkg::res_t   res
);
	import erd_pkg::*;

	logic [TICK_W-1:0] ticks_inc;
	logic              expired;
	logic [TMO_W:0]    backoff;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] frame_end;

	assign ticks_inc = (st.ack_ticks < TICK_SAT) ? st.ack_ticks + 16'd1 : st.ack_ticks;
	assign expired   = {1'b0, ticks_inc} >= st.current_timeout;
	assign backoff   = {st.current_timeout, 1'b0} + (TMO_W+1)'(req.jitter);
	assign base      = req.priority_req ? cfg.priority_buf_start : cfg.optional_buf_start;
	assign frame_end = base + ADDR_W'(ETH_HDR_BYTES) + ADDR_W'(req.payload_length);

	always_comb begin
		st_next = st;
		res     = '0;
		unique case (req.kind)
			KIND_TICK: begin
				st_next.ack_ticks = ticks_inc;
				if (expired) begin
					st_next.ack_ticks = '0;
					if (st.pending_valid) begin
						if (st.current_timeout >= {1'b0, cfg.timeout_max}) begin
							res.fatal = FATAL_NO_ACK;
						end else begin
							st_next.current_timeout = (backoff > {1'b0, TIMEOUT_CAP})
								? TIMEOUT_CAP : backoff[TMO_W-1:0];
							res.action   = ACT_TRANSMIT;
							res.tx_start = cfg.priority_buf_start;
							res.tx_end   = st.pending_end;
						end
					end
				end
			end
			KIND_SEND: begin
				if (req.priority_req) begin
					st_next.pending_end     = frame_end;
					st_next.pending_valid   = 1'b1;
					st_next.ack_ticks       = '0;
					st_next.current_timeout = {1'b0, cfg.timeout_min};
				end
				res.action   = ACT_TRANSMIT;
				res.tx_start = base;
				res.tx_end   = frame_end;
			end
			KIND_RECV: begin
				res.header_address  = st.next_header;
				st_next.next_header = req.nxt_frame_ptr;
				res.delivered_length =
					(req.frame_bytes > LEN_W'(ETH_HDR_BYTES + ETH_CRC_BYTES))
					? req.frame_bytes - LEN_W'(ETH_HDR_BYTES + ETH_CRC_BYTES) : '0;
				priority if (req.src_mac == cfg.local_mac) res.action = ACT_DROP;
				else if (req.ethertype == TYPE_IP)        res.action = ACT_IP;
				else if (req.ethertype == TYPE_ARP)       res.action = ACT_ARP;
				else                                      res.action = ACT_DROP;
				if (req.nxt_frame_ptr > cfg.rx_buf_end) begin
					res.fatal = FATAL_RX_PTR;
				end
				res.read_pointer = (req.nxt_frame_ptr == '0) ? cfg.rx_buf_end
					: req.nxt_frame_ptr - 13'd1;
			end
			default: begin
				st_next = st;
				res     = '0;
			end
		endcase
	end

endmodule
